### hw/rtl/hfd_pkg.sv
// Package for the table-driven Huffman bit decoder.
// Field widths, command codes, register indexes and the item types.
// No dependencies.
package hfd_pkg;

	localparam int SYM_W    = 8;
	localparam int CODE_W   = 31;
	localparam int LEN_W    = 5;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int SKIP_W   = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_BITS   = 1'd1;

	// one input item as held in the queue
	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [SYM_W-1:0]  entry_symbol;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0]  entry_length;
		logic [DATA_W-1:0] data_word;
	} item_t;

	// one code table entry
	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// handshake between queue and decoder
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

### hw/rtl/hfd_item_if.sv
// Input channel of the Huffman bit decoder: valid/ready plus item fields.
// Depends on hfd_pkg.
interface hfd_item_if import hfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [IDX_W-1:0]  entry_index;
	logic [SYM_W-1:0]  entry_symbol;
	logic [CODE_W-1:0] entry_code;
	logic [LEN_W-1:0]  entry_length;
	logic [DATA_W-1:0] data_word;

	modport source (output valid, cmd, entry_index, entry_symbol, entry_code,
		entry_length, data_word, input ready);
	modport sink (input valid, cmd, entry_index, entry_symbol, entry_code,
		entry_length, data_word, output ready);
endinterface

### hw/rtl/hfd_result_if.sv
// Result channel of the Huffman bit decoder: valid/ready plus result fields.
// Depends on hfd_pkg.
interface hfd_result_if import hfd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             code_error;
	logic             last;

	modport source (output valid, symbol, code_error, last, input ready);
	modport sink (input valid, symbol, code_error, last, output ready);
endinterface

### hw/rtl/hfd_front.sv
// Front end: accepts input items into a two-entry queue for the decoder.
// Depends on hfd_pkg and hfd_item_if.
module hfd_front import hfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	hfd_item_if.sink     items,
	output q_head_t      head,
	input  logic         pop
);

	item_t       buf_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        do_pop;
	item_t       in_item;

	assign items.ready = (cnt_q != 2'd2);
	assign push   = items.valid && items.ready;
	assign do_pop = pop && (cnt_q != 2'd0);

	assign in_item = '{cmd: items.cmd, entry_index: items.entry_index,
		entry_symbol: items.entry_symbol, entry_code: items.entry_code,
		entry_length: items.entry_length, data_word: items.data_word};

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = buf_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/hfd_back.sv
// Back end: code table memory, bit-serial decode with table scan, result register.
// Depends on hfd_pkg and hfd_result_if.
module hfd_back import hfd_pkg::*; #(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_CODE_LEN = 31,
	parameter int WORD_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  q_head_t             head,
	output logic                pop,
	input  logic [CNT_W-1:0]    entry_count,
	input  logic [SKIP_W-1:0]   skip_bits,
	hfd_result_if.source        results
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int PLW = $clog2(MAX_CODE_LEN + 1);
	localparam int BLW = $clog2(WORD_BITS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_RES   = 3'd3;
	localparam logic [2:0] ST_NEXT  = 3'd4;
	localparam logic [2:0] ST_END   = 3'd5;

	localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [BLW-1:0]    WB_C    = BLW'(WORD_BITS);
	localparam logic [SKIP_W:0]   WB_SK_C = (SKIP_W+1)'(WORD_BITS);
	localparam logic [PLW-1:0]    MAXL_C  = PLW'(MAX_CODE_LEN);

	entry_t                mem [TABLE_DEPTH];
	entry_t                rd_data_s1;
	logic                  rv_s1;
	logic [2:0]            state_q;
	logic [WORD_BITS-1:0]  word_q;
	logic [BLW-1:0]        left_q;
	logic [MAX_CODE_LEN-1:0] pcode_q;
	logic [PLW-1:0]        plen_q;
	logic                  first_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [SYM_W-1:0]      res_sym_q;
	logic                  res_err_q;
	logic                  hold_v_q;
	logic [SYM_W-1:0]      hold_sym_q;
	logic                  hold_err_q;
	logic                  out_v_q;
	logic [SYM_W-1:0]      out_sym_q;
	logic                  out_err_q;
	logic                  out_last_q;

	logic [CNT_W-1:0]      n_srch;
	logic                  issue;
	logic                  match;
	logic                  out_free;
	logic                  push;
	logic                  push_last;
	logic [BLW-1:0]        start;
	logic                  mem_we;
	logic [WORD_BITS-1:0]  word_in;

	assign results.valid      = out_v_q;
	assign results.symbol     = out_sym_q;
	assign results.code_error = out_err_q;
	assign results.last       = out_last_q;

	// slots searched, capped at the table depth
	assign n_srch = (entry_count > DEPTH_C) ? DEPTH_C : entry_count;
	assign issue  = (state_q == ST_SCAN) && (rd_idx_q < n_srch);
	assign match  = rv_s1 && (rd_data_s1.len == LEN_W'(plen_q))
		&& (rd_data_s1.code == CODE_W'(pcode_q));

	assign out_free = !out_v_q || results.ready;

	// skip count for the first word, capped at the word size
	always_comb begin
		start = '0;
		if (first_q) begin
			start = ({1'b0, skip_bits} >= WB_SK_C) ? WB_C : BLW'(skip_bits);
		end
	end
	assign word_in = head.item.data_word[WORD_BITS-1:0] << start;

	assign pop    = (state_q == ST_IDLE) && head.valid;
	assign mem_we = pop && (head.item.cmd == CMD_LOAD)
		&& ({1'b0, head.item.entry_index} < CNT_W'(TABLE_DEPTH));

	// held result moves to the output register when a newer one arrives
	// or the word ends
	always_comb begin
		push      = 1'b0;
		push_last = 1'b0;
		if (hold_v_q && out_free) begin
			if (state_q == ST_RES) begin
				push = 1'b1;
			end else if (state_q == ST_END) begin
				push      = 1'b1;
				push_last = 1'b1;
			end
		end
	end

	// code table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.item.entry_index[AW-1:0]] <= '{sym: head.item.entry_symbol,
				code: head.item.entry_code, len: head.item.entry_length};
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (push) begin
			out_sym_q  <= hold_sym_q;
			out_err_q  <= hold_err_q;
			out_last_q <= push_last;
		end
		if (pop && head.item.cmd == CMD_DATA) begin
			word_q <= word_in;
		end else if (state_q == ST_SHIFT) begin
			word_q <= word_q << 1;
		end
		if (state_q == ST_SCAN) begin
			if (match) begin
				res_sym_q <= rd_data_s1.sym;
				res_err_q <= 1'b0;
			end else begin
				res_sym_q <= '0;
				res_err_q <= 1'b1;
			end
		end
		if (state_q == ST_RES && (!hold_v_q || out_free)) begin
			hold_sym_q <= res_sym_q;
			hold_err_q <= res_err_q;
		end
	end

	// decode sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			left_q   <= '0;
			pcode_q  <= '0;
			plen_q   <= '0;
			first_q  <= 1'b1;
			rd_idx_q <= '0;
			rv_s1    <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (results.ready && out_v_q) begin
				out_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.item.cmd == CMD_DATA) begin
						first_q <= 1'b0;
						left_q  <= WB_C - start;
						state_q <= (start == WB_C) ? ST_END : ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					pcode_q  <= {pcode_q[MAX_CODE_LEN-2:0], word_q[WORD_BITS-1]};
					plen_q   <= plen_q + PLW'(1);
					left_q   <= left_q - BLW'(1);
					rd_idx_q <= '0;
					rv_s1    <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					rv_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (match) begin
						rv_s1   <= 1'b0;
						state_q <= ST_RES;
					end else if (!rv_s1 && !issue) begin
						state_q <= (plen_q >= MAXL_C) ? ST_RES : ST_NEXT;
					end
				end
				ST_RES: begin
					if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b1;
						pcode_q  <= '0;
						plen_q   <= '0;
						state_q  <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					state_q <= (left_q == '0) ? ST_END : ST_SHIFT;
				end
				ST_END: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/huffman_table_bit_decoder.sv
// Huffman decoder with an explicit code table: top level.
// Channels: items (sink) carries load and data items; results (source) carries
// decoded symbols. cmd 0 writes one table slot, cmd 1 brings a word of
// WORD_BITS compressed bits decoded MSB first.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 is entry_count, index 1 is
// skip_bits (applies to the first data word after reset only).
// Decode: each data bit is shifted into the partial code, then a table scan
// reads one slot per cycle, up to entry_count slots (capped at TABLE_DEPTH);
// a hit ends the scan early. A two-entry input queue keeps accepting items
// while the decoder works, until it is full; the result register holds one
// transfer, and a stalled receiver stops the decoder only when a new result
// must be handed over. Reset clears the partial code, the valid flags and the
// configuration registers and sets the first-word flag; the table contents
// stay undefined until loaded. Results are delayed by one: each is released
// when the next one is found or the word ends (last = 1).
// Depends on hfd_pkg, hfd_item_if, hfd_result_if, hfd_front, hfd_back.
module huffman_table_bit_decoder import hfd_pkg::*; #(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_CODE_LEN = 31,
	parameter int WORD_BITS    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hfd_item_if.sink              items,
	hfd_result_if.source          results
);

	logic [CNT_W-1:0]  entry_count_q;
	logic [SKIP_W-1:0] skip_bits_q;
	q_head_t           head;
	logic              pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			skip_bits_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_COUNT: entry_count_q <= cfg_data[CNT_W-1:0];
				REG_SKIP_BITS:   skip_bits_q   <= cfg_data[SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	hfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.head   (head),
		.pop    (pop)
	);

	hfd_back #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.WORD_BITS    (WORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.entry_count (entry_count_q),
		.skip_bits   (skip_bits_q),
		.results     (results)
	);

endmodule
